FILE: rtl/rusi_pkg.sv
package rusi_pkg;

    localparam int COORD_W = 24;
    localparam int DIST_W  = 32;
    localparam int TOL_W   = 16;
    localparam int PROD_W  = 48;
    localparam int A_W     = 49;
    localparam int H_W     = 50;
    localparam int HALF_LO = 25;
    localparam int HALF_HI = 24;
    localparam int WIDE_W  = 98;
    localparam int D_W     = 80;
    localparam int S_W     = 40;
    localparam int REM_W   = 43;
    localparam int NUM_W   = 52;
    localparam int DREM_W  = 50;
    localparam int Q_W     = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;
    localparam logic             TOL_INDEX = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [DIST_W-1:0]         nearest_distance;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } out_item_t;

    typedef struct packed {
        logic                    ok;
        logic                    sat;
        logic [A_W-1:0]          a;
        logic signed [H_W-1:0]   h;
        logic [DIST_W-1:0]       nearest;
    } side_t;

endpackage

FILE: rtl/ray_unit_sphere_intersect_top.sv
// Ray against unit sphere intersection test in fixed point.
// The input channel (in_valid, in_stall, in_data) carries one ray per transaction: origin
// and direction in the sphere's object space as signed Q8.16, plus the current nearest hit
// distance as Q16.16. The output channel (out_valid, out_stall, out_data) returns one
// transaction per ray: a hit flag and the new distance, or the old one when there is no hit.
// The pipeline takes one ray every cycle while the receiver does not stall: five stages
// form the dot products and the discriminant, a chain of 40 square root cells produces one
// root bit per cell, one stage picks the root, and a chain of 32 divider cells produces one
// quotient bit per cell, followed by the output register.
// When the receiver stalls while a result is waiting, the whole pipeline holds and in_stall
// is raised in the same cycle; nothing is dropped.
// Reset clears all valid flags and loads the tolerance register with 66. The tolerance is
// written over the APB port at byte address 0 and should only be changed while the block
// holds no rays in flight.
module ray_unit_sphere_intersect_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rusi_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rusi_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int S_W = rusi_pkg::S_W;
    localparam int Q_W = rusi_pkg::Q_W;

    logic                           adv;
    logic [rusi_pkg::TOL_W-1:0]     tol_reg;

    logic                           v1_reg;
    logic signed [rusi_pkg::PROD_W-1:0] pdd_reg [0:2];
    logic signed [rusi_pkg::PROD_W-1:0] pdo_reg [0:2];
    logic signed [rusi_pkg::PROD_W-1:0] poo_reg [0:2];
    logic [rusi_pkg::DIST_W-1:0]    near1_reg;

    logic                           v2_reg;
    logic [rusi_pkg::A_W-1:0]       a2_reg;
    logic signed [rusi_pkg::H_W-1:0] h2_reg;
    logic signed [rusi_pkg::H_W-1:0] c2_reg;
    logic [rusi_pkg::DIST_W-1:0]    near2_reg;
    logic [rusi_pkg::A_W-1:0]       a2_next;
    logic signed [rusi_pkg::H_W-1:0] h2_next;
    logic signed [rusi_pkg::H_W-1:0] c2_next;

    logic [rusi_pkg::A_W-1:0]       habs;
    logic [rusi_pkg::A_W-1:0]       cabs;
    logic                           v3_reg;
    logic                           cneg3_reg;
    logic [2*rusi_pkg::HALF_HI-1:0] hhh_reg;
    logic [rusi_pkg::HALF_HI+rusi_pkg::HALF_LO-1:0] hhl_reg;
    logic [2*rusi_pkg::HALF_LO-1:0] hll_reg;
    logic [2*rusi_pkg::HALF_HI-1:0] ahh_reg;
    logic [rusi_pkg::HALF_HI+rusi_pkg::HALF_LO-1:0] ahl_reg;
    logic [rusi_pkg::HALF_HI+rusi_pkg::HALF_LO-1:0] alh_reg;
    logic [2*rusi_pkg::HALF_LO-1:0] all_reg;
    logic [rusi_pkg::A_W-1:0]       a3_reg;
    logic signed [rusi_pkg::H_W-1:0] h3_reg;
    logic [rusi_pkg::DIST_W-1:0]    near3_reg;

    logic                           v4_reg;
    logic                           cneg4_reg;
    logic [rusi_pkg::WIDE_W-1:0]    hsq4_reg;
    logic [rusi_pkg::WIDE_W-1:0]    ac4_reg;
    logic [rusi_pkg::WIDE_W-1:0]    hsq4_next;
    logic [rusi_pkg::WIDE_W-1:0]    ac4_next;
    logic [rusi_pkg::A_W-1:0]       a4_reg;
    logic signed [rusi_pkg::H_W-1:0] h4_reg;
    logic [rusi_pkg::DIST_W-1:0]    near4_reg;

    logic signed [rusi_pkg::WIDE_W-1:0] disc;
    logic signed [rusi_pkg::WIDE_W-1:0] disc_thr;
    logic                           v5_reg;
    rusi_pkg::side_t                side5_reg;
    logic [rusi_pkg::D_W-1:0]       d5_reg;

    logic                           sq_v    [0:S_W];
    rusi_pkg::side_t                sq_side [0:S_W];
    logic [rusi_pkg::REM_W-1:0]     sq_rem  [0:S_W];
    logic [rusi_pkg::S_W-1:0]       sq_root [0:S_W];
    logic [rusi_pkg::D_W-1:0]       sq_rad  [0:S_W];

    logic signed [rusi_pkg::NUM_W-1:0] root_thr;
    logic signed [rusi_pkg::NUM_W-1:0] num_near;
    logic signed [rusi_pkg::NUM_W-1:0] num_far;
    logic signed [rusi_pkg::NUM_W-1:0] num_sel;
    logic                           near_ok;
    logic                           far_ok;
    rusi_pkg::side_t                side6_next;
    logic                           v6_reg;
    rusi_pkg::side_t                side6_reg;
    logic [rusi_pkg::DREM_W-1:0]    rem6_reg;
    logic [Q_W-1:0]                 x6_reg;

    logic                           dv_v    [0:Q_W];
    rusi_pkg::side_t                dv_side [0:Q_W];
    logic [rusi_pkg::DREM_W-1:0]    dv_rem  [0:Q_W];
    logic [Q_W-1:0]                 dv_q    [0:Q_W];
    logic [Q_W-1:0]                 dv_x    [0:Q_W];

    logic [Q_W-1:0]                 t_val;
    rusi_pkg::out_item_t            out_next;
    logic                           out_valid_reg;
    rusi_pkg::out_item_t            out_data_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == rusi_pkg::TOL_INDEX) ? 32'(tol_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= rusi_pkg::TOL_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == rusi_pkg::TOL_INDEX))
        begin
            tol_reg <= pwdata[rusi_pkg::TOL_W-1:0];
        end
    end

    always_comb
    begin
        a2_next = rusi_pkg::A_W'(pdd_reg[0]) + rusi_pkg::A_W'(pdd_reg[1])
                + rusi_pkg::A_W'(pdd_reg[2]);
        h2_next = rusi_pkg::H_W'(pdo_reg[0]) + rusi_pkg::H_W'(pdo_reg[1])
                + rusi_pkg::H_W'(pdo_reg[2]);
        c2_next = rusi_pkg::H_W'(poo_reg[0]) + rusi_pkg::H_W'(poo_reg[1])
                + rusi_pkg::H_W'(poo_reg[2]) - (rusi_pkg::H_W'(1) <<< 32);
        habs = h2_reg[rusi_pkg::H_W-1] ? rusi_pkg::A_W'(-h2_reg) : rusi_pkg::A_W'(h2_reg);
        cabs = c2_reg[rusi_pkg::H_W-1] ? rusi_pkg::A_W'(-c2_reg) : rusi_pkg::A_W'(c2_reg);
        hsq4_next = (rusi_pkg::WIDE_W'(hhh_reg) << 50) + (rusi_pkg::WIDE_W'(hhl_reg) << 26)
                  + rusi_pkg::WIDE_W'(hll_reg);
        ac4_next  = (rusi_pkg::WIDE_W'(ahh_reg) << 50)
                  + ((rusi_pkg::WIDE_W'(ahl_reg) + rusi_pkg::WIDE_W'(alh_reg)) << 25)
                  + rusi_pkg::WIDE_W'(all_reg);
        disc     = cneg4_reg ? $signed(hsq4_reg + ac4_reg) : $signed(hsq4_reg - ac4_reg);
        disc_thr = $signed(rusi_pkg::WIDE_W'(tol_reg) << 46);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= sq_v[S_W];
            out_valid_reg <= dv_v[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdd_reg[0] <= in_data.dir_x * in_data.dir_x;
            pdd_reg[1] <= in_data.dir_y * in_data.dir_y;
            pdd_reg[2] <= in_data.dir_z * in_data.dir_z;
            pdo_reg[0] <= in_data.dir_x * in_data.origin_x;
            pdo_reg[1] <= in_data.dir_y * in_data.origin_y;
            pdo_reg[2] <= in_data.dir_z * in_data.origin_z;
            poo_reg[0] <= in_data.origin_x * in_data.origin_x;
            poo_reg[1] <= in_data.origin_y * in_data.origin_y;
            poo_reg[2] <= in_data.origin_z * in_data.origin_z;
            near1_reg  <= in_data.nearest_distance;

            a2_reg    <= a2_next;
            h2_reg    <= h2_next;
            c2_reg    <= c2_next;
            near2_reg <= near1_reg;

            hhh_reg   <= habs[48:25] * habs[48:25];
            hhl_reg   <= habs[48:25] * habs[24:0];
            hll_reg   <= habs[24:0] * habs[24:0];
            ahh_reg   <= a2_reg[48:25] * cabs[48:25];
            ahl_reg   <= a2_reg[48:25] * cabs[24:0];
            alh_reg   <= a2_reg[24:0] * cabs[48:25];
            all_reg   <= a2_reg[24:0] * cabs[24:0];
            cneg3_reg <= c2_reg[rusi_pkg::H_W-1];
            a3_reg    <= a2_reg;
            h3_reg    <= h2_reg;
            near3_reg <= near2_reg;

            hsq4_reg  <= hsq4_next;
            ac4_reg   <= ac4_next;
            cneg4_reg <= cneg3_reg;
            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            near4_reg <= near3_reg;

            d5_reg            <= disc[rusi_pkg::D_W-1:0];
            side5_reg.ok      <= (disc > disc_thr);
            side5_reg.sat     <= 1'b0;
            side5_reg.a       <= a4_reg;
            side5_reg.h       <= h4_reg;
            side5_reg.nearest <= near4_reg;

            side6_reg <= side6_next;
            rem6_reg  <= rusi_pkg::DREM_W'(num_sel[rusi_pkg::NUM_W-1:16]);
            x6_reg    <= {num_sel[15:0], 16'd0};

            out_data_reg <= out_next;
        end
    end

    assign sq_v[0]    = v5_reg;
    assign sq_side[0] = side5_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = d5_reg;

    for (genvar i = 0; i < S_W; i++)
    begin : g_sqrt
        rusi_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (sq_v[i]),
            .in_side   (sq_side[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_rad    (sq_rad[i]),
            .out_valid (sq_v[i+1]),
            .out_side  (sq_side[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rad   (sq_rad[i+1])
        );
    end

    always_comb
    begin
        root_thr = $signed(rusi_pkg::NUM_W'(tol_reg) << 15);
        num_near = -rusi_pkg::NUM_W'(sq_side[S_W].h)
                 - $signed(rusi_pkg::NUM_W'(sq_root[S_W]));
        num_far  = -rusi_pkg::NUM_W'(sq_side[S_W].h)
                 + $signed(rusi_pkg::NUM_W'(sq_root[S_W]));
        near_ok  = (num_near > root_thr);
        far_ok   = (num_far > root_thr);
        num_sel  = near_ok ? num_near : num_far;
        side6_next     = sq_side[S_W];
        side6_next.ok  = sq_side[S_W].ok && (near_ok || far_ok);
        side6_next.sat = ({16'd0, num_sel[rusi_pkg::NUM_W-2:0]}
                          >= ({18'd0, sq_side[S_W].a} << 16));
    end

    assign dv_v[0]    = v6_reg;
    assign dv_side[0] = side6_reg;
    assign dv_rem[0]  = rem6_reg;
    assign dv_q[0]    = '0;
    assign dv_x[0]    = x6_reg;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        rusi_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (dv_v[j]),
            .in_side   (dv_side[j]),
            .in_rem    (dv_rem[j]),
            .in_q      (dv_q[j]),
            .in_x      (dv_x[j]),
            .out_valid (dv_v[j+1]),
            .out_side  (dv_side[j+1]),
            .out_rem   (dv_rem[j+1]),
            .out_q     (dv_q[j+1]),
            .out_x     (dv_x[j+1])
        );
    end

    always_comb
    begin
        t_val = dv_side[Q_W].sat ? '1 : dv_q[Q_W];
        out_next.hit      = dv_side[Q_W].ok && (t_val < dv_side[Q_W].nearest);
        out_next.distance = out_next.hit ? t_val : dv_side[Q_W].nearest;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow a held result");

    a_hit_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.distance != '1))
        else $error("hit reported at saturated distance");

    a_tol_only_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(psel && penable && pwrite) |=> $stable(tol_reg))
        else $error("tolerance changed without a write transaction");

endmodule

FILE: rtl/rusi_sqrt_cell.sv
module rusi_sqrt_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  rusi_pkg::side_t            in_side,
    input  logic [rusi_pkg::REM_W-1:0] in_rem,
    input  logic [rusi_pkg::S_W-1:0]   in_root,
    input  logic [rusi_pkg::D_W-1:0]   in_rad,
    output logic                       out_valid,
    output rusi_pkg::side_t            out_side,
    output logic [rusi_pkg::REM_W-1:0] out_rem,
    output logic [rusi_pkg::S_W-1:0]   out_root,
    output logic [rusi_pkg::D_W-1:0]   out_rad
);

    logic [rusi_pkg::REM_W-1:0] rem_sh;
    logic [rusi_pkg::REM_W-1:0] trial;
    logic                       ge;
    logic [rusi_pkg::REM_W-1:0] rem_next;
    logic [rusi_pkg::S_W-1:0]   root_next;
    logic [rusi_pkg::D_W-1:0]   rad_next;
    logic                       valid_reg;
    rusi_pkg::side_t            side_reg;
    logic [rusi_pkg::REM_W-1:0] rem_reg;
    logic [rusi_pkg::S_W-1:0]   root_reg;
    logic [rusi_pkg::D_W-1:0]   rad_reg;

    always_comb
    begin
        rem_sh    = {in_rem[rusi_pkg::REM_W-3:0], in_rad[rusi_pkg::D_W-1:rusi_pkg::D_W-2]};
        trial     = {1'b0, in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[rusi_pkg::S_W-2:0], ge};
        rad_next  = {in_rad[rusi_pkg::D_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;

endmodule

FILE: rtl/rusi_div_cell.sv
module rusi_div_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rusi_pkg::side_t             in_side,
    input  logic [rusi_pkg::DREM_W-1:0] in_rem,
    input  logic [rusi_pkg::Q_W-1:0]    in_q,
    input  logic [rusi_pkg::Q_W-1:0]    in_x,
    output logic                        out_valid,
    output rusi_pkg::side_t             out_side,
    output logic [rusi_pkg::DREM_W-1:0] out_rem,
    output logic [rusi_pkg::Q_W-1:0]    out_q,
    output logic [rusi_pkg::Q_W-1:0]    out_x
);

    logic [rusi_pkg::DREM_W-1:0] rem_sh;
    logic [rusi_pkg::DREM_W-1:0] divisor;
    logic                        ge;
    logic                        valid_reg;
    rusi_pkg::side_t             side_reg;
    logic [rusi_pkg::DREM_W-1:0] rem_reg;
    logic [rusi_pkg::DREM_W-1:0] rem_next;
    logic [rusi_pkg::Q_W-1:0]    q_reg;
    logic [rusi_pkg::Q_W-1:0]    q_next;
    logic [rusi_pkg::Q_W-1:0]    x_reg;
    logic [rusi_pkg::Q_W-1:0]    x_next;

    always_comb
    begin
        rem_sh   = {in_rem[rusi_pkg::DREM_W-2:0], in_x[rusi_pkg::Q_W-1]};
        divisor  = rusi_pkg::DREM_W'(in_side.a);
        ge       = (rem_sh >= divisor);
        rem_next = ge ? (rem_sh - divisor) : rem_sh;
        q_next   = {in_q[rusi_pkg::Q_W-2:0], ge};
        x_next   = {in_x[rusi_pkg::Q_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            x_reg    <= x_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_x     = x_reg;

endmodule

FILE: tb/sv/tb_ray_unit_sphere_intersect_top.sv
`timescale 1ns / 100ps

module tb_ray_unit_sphere_intersect_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int ITEMS_PER_PHASE = 160;
    localparam logic [2:0] TOL_ADDR = 3'(4 * rusi_pkg::TOL_INDEX);
    localparam int ONE = 65536;

    typedef struct {
        rusi_pkg::in_item_t  ray;
        bit                  known;
        rusi_pkg::out_item_t want;
    } ray_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    rusi_pkg::in_item_t     in_data;
    logic                   out_valid;
    logic                   out_stall;
    rusi_pkg::out_item_t    out_data;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    logic [rusi_pkg::TOL_W-1:0] tol_model;
    rusi_pkg::out_item_t        pending_hits[$];
    ray_row_t                   ray_rows[$];
    int                         failures;
    int                         quiet_cycles;
    int                         send_idle_pct;
    int                         recv_stall_pct;

    ray_unit_sphere_intersect_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rusi_pkg::out_item_t sphere_hit_predict(rusi_pkg::in_item_t ray);
        longint ox, oy, oz, dx, dy, dz, a, h, c, num, root_thr;
        logic signed [127:0] hw, aw, cw, disc, thr;
        logic [127:0] cand;
        longint unsigned root, q, r, t;
        rusi_pkg::out_item_t res;
        ox = ray.origin_x;
        oy = ray.origin_y;
        oz = ray.origin_z;
        dx = ray.dir_x;
        dy = ray.dir_y;
        dz = ray.dir_z;
        res.hit = 1'b0;
        res.distance = ray.nearest_distance;
        a = dx * dx + dy * dy + dz * dz;
        h = dx * ox + dy * oy + dz * oz;
        c = ox * ox + oy * oy + oz * oz - (longint'(1) <<< 32);
        hw = h;
        aw = a;
        cw = c;
        disc = hw * hw - aw * cw;
        thr = {112'b0, tol_model};
        thr = thr <<< 46;
        if (disc <= thr || a <= 0)
            return res;
        root = 0;
        for (int b = 49; b >= 0; b--)
        begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= $unsigned(disc))
                root = cand[63:0];
        end
        root_thr = longint'(tol_model) * 32768;
        num = -h - longint'(root);
        if (num <= root_thr)
        begin
            num = -h + longint'(root);
            if (num <= root_thr)
                return res;
        end
        q = unsigned'(num) / unsigned'(a);
        r = unsigned'(num) % unsigned'(a);
        if (q >= 65536)
            t = 64'hFFFF_FFFF;
        else
            t = (q << 16) + ((r << 16) / unsigned'(a));
        if (t < ray.nearest_distance)
        begin
            res.hit = 1'b1;
            res.distance = t[31:0];
        end
        return res;
    endfunction

    function automatic rusi_pkg::in_item_t make_ray(int ox, int oy, int oz,
                                                    int dx, int dy, int dz,
                                                    logic [31:0] nearest);
        rusi_pkg::in_item_t ray;
        ray.origin_x = ox[23:0];
        ray.origin_y = oy[23:0];
        ray.origin_z = oz[23:0];
        ray.dir_x = dx[23:0];
        ray.dir_y = dy[23:0];
        ray.dir_z = dz[23:0];
        ray.nearest_distance = nearest;
        return ray;
    endfunction

    task automatic add_row(rusi_pkg::in_item_t ray, bit known, logic hit,
                           logic [31:0] want_distance);
        ray_row_t row;
        row.ray = ray;
        row.known = known;
        row.want.hit = hit;
        row.want.distance = want_distance;
        ray_rows.push_back(row);
    endtask

    function automatic int spread(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic rusi_pkg::in_item_t random_ray();
        rusi_pkg::in_item_t ray;
        logic [191:0] raw_bits;
        int ox, oy, oz, tx, ty, tz, sh;
        if ($urandom_range(0, 99) < 15)
        begin
            raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            ray = raw_bits[175:0];
            return ray;
        end
        ox = spread(4 * ONE);
        oy = spread(4 * ONE);
        oz = spread(4 * ONE);
        tx = spread(ONE + ONE / 4);
        ty = spread(ONE + ONE / 4);
        tz = spread(ONE + ONE / 4);
        sh = $urandom_range(0, 6);
        ray = make_ray(ox, oy, oz, (tx - ox) >>> sh, (ty - oy) >>> sh, (tz - oz) >>> sh,
                       $urandom_range(0, 2) == 0 ? 32'hFFFF_FFFF
                                                 : 32'($urandom_range(0, 32'h0008_0000)));
        return ray;
    endfunction

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = TOL_ADDR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        tol_model = value[rusi_pkg::TOL_W-1:0];
        @(negedge clk);
        psel = 1'b1;
        paddr = TOL_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[rusi_pkg::TOL_W-1:0] !== tol_model)
        begin
            $error("tolerance readback: expected %0d, actual %0d", tol_model, prdata);
            failures++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_ray(rusi_pkg::in_item_t ray, bit known, rusi_pkg::out_item_t want);
        rusi_pkg::out_item_t pred;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = ray;
        pred = sphere_hit_predict(ray);
        if (known && pred !== want)
        begin
            $error("directed row: predictor gives hit %0b distance %h, table %0b %h",
                   pred.hit, pred.distance, want.hit, want.distance);
            failures++;
        end
        do
            @(posedge clk);
        while (in_stall);
        pending_hits.push_back(known ? want : pred);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ray_unit_sphere_intersect_top test failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected transaction: hit %0b distance %h",
                       out_data.hit, out_data.distance);
                failures++;
            end
            else
            begin
                if (out_data.hit !== pending_hits[0].hit)
                begin
                    $error("hit: expected %0b, actual %0b", pending_hits[0].hit, out_data.hit);
                    failures++;
                end
                if (out_data.distance !== pending_hits[0].distance)
                begin
                    $error("distance: expected %h, actual %h",
                           pending_hits[0].distance, out_data.distance);
                    failures++;
                end
                void'(pending_hits.pop_front());
            end
        end
    end

    initial
    begin
        rusi_pkg::out_item_t none;
        logic [15:0] tol_settings[4];
        none = '0;
        failures = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tol_model = rusi_pkg::TOL_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(make_ray(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, 1'b0, 32'hFFFF_FFFF);
        add_row(make_ray(0, 0, -2 * ONE, 0, 0, ONE, 32'hFFFF_FFFF), 1, 1'b1, 32'h0001_0000);
        add_row(make_ray(0, 0, -2 * ONE, 0, 0, ONE, 32'h0001_0000), 1, 1'b0, 32'h0001_0000);
        add_row(make_ray(0, 0, -2 * ONE, 0, 0, ONE, 32'h0001_0001), 1, 1'b1, 32'h0001_0000);
        add_row(make_ray(0, 0, -2 * ONE, 0, 0, ONE, 32'h0000_0000), 1, 1'b0, 32'h0000_0000);
        add_row(make_ray(0, 0, 0, 0, 0, ONE, 32'hFFFF_FFFF), 1, 1'b1, 32'h0001_0000);
        add_row(make_ray(0, 0, 2 * ONE, 0, 0, ONE, 32'hFFFF_FFFF), 1, 1'b0, 32'hFFFF_FFFF);
        add_row(make_ray(0, 2 * ONE, -2 * ONE, 0, 0, ONE, 32'h1234_5678), 1, 1'b0,
                32'h1234_5678);
        add_row(make_ray(0, ONE, -2 * ONE, 0, 0, ONE, 32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(0, 0, -127 * ONE, 0, 0, 1, 32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(0, 0, -127 * ONE, 0, 0, 1, 32'hFFFF_FFFE), 0, 1'b0, 0);
        add_row(make_ray(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                         32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                         32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                         32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(-8388608, 0, 0, 8388607, 0, 0, 32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(ONE / 2, ONE / 2, -3 * ONE, 0, 1, 2 * ONE, 32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(0, ONE - 8, -4 * ONE, 0, 0, ONE, 32'hFFFF_FFFF), 0, 1'b0, 0);
        add_row(make_ray(-1, -1, -1, -1, -1, -1, 32'h0000_0001), 0, 1'b0, 0);

        foreach (ray_rows[i])
            send_ray(ray_rows[i].ray, ray_rows[i].known, ray_rows[i].want);
        drain();

        tol_settings = '{16'd0, 16'hFFFF, 16'd66, 16'd0};
        tol_settings[3] = 16'($urandom_range(1, 4000));
        for (int phase = 0; phase < 4; phase++)
        begin
            apb_write({16'b0, tol_settings[phase]});
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2)
                begin
                    in_valid = 1'b0;
                    while (pending_hits.size() != 0)
                        @(negedge clk);
                end
                send_ray(random_ray(), 0, none);
            end
            drain();
        end

        if (failures == 0)
            $display("ray_unit_sphere_intersect_top test passed");
        else
            $display("ray_unit_sphere_intersect_top test failed");
        $finish;
    end

endmodule
